/* sv/pas_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, constants and helpers for the priority aging process
// scheduler.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int PRIO_W    = 16;
    localparam int SLOT_OUT_W = 4;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX      = 16'sh7fff;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN      = 16'sh8000;
    localparam logic signed [PRIO_W-1:0] DEMOTE_CEIL   = 16'sd1000;
    localparam logic signed [PRIO_W-1:0] PRIO_ZERO     = 16'sd0;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_TICK    = 3'd1,
        OP_YIELD   = 3'd2,
        OP_FORK    = 3'd3,
        OP_KILL    = 3'd4,
        OP_EXIT    = 3'd5,
        OP_SETPRIO = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KILL,
        S_SCAN,
        S_SCAN_DRAIN,
        S_ALLOC,
        S_SCHED,
        S_AGE,
        S_AGE_DRAIN,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic acc_clr;
        logic rd_en;
        logic age;
        logic alloc;
        logic fork_prio;
        logic sched;
        logic kill;
        logic exit_wr;
        logic prio_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } t_stat;

    function automatic logic signed [PRIO_W-1:0] sat_inc(
        input logic signed [PRIO_W-1:0] p
    );
        return (p == PRIO_MAX) ? PRIO_MAX : p + 16'sd1;
    endfunction

    function automatic logic signed [PRIO_W-1:0] demote(
        input logic signed [PRIO_W-1:0] low
    );
        logic signed [PRIO_W-1:0] res;
        if (low == DEMOTE_CEIL) begin
            res = PRIO_ZERO;
        end else if (low == PRIO_MIN) begin
            res = PRIO_MIN;
        end else begin
            res = low - 16'sd1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/pas_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pas_ctrl
// Command sequencer: steps each request through kill, table scans, allocation,
// scheduling and aging, or through the exit and set-priority table writes.
// ----------------------------------------------------------------------------
module pas_ctrl
    import pas_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_opcode,
    input  wire t_stat      i_stat,
    output logic            o_ready,
    output t_cmd            o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_alloc_done, n_alloc_done;
    t_op    w_in_op;

    assign w_in_op = t_op'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_TICK;
            r_alloc_done <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_alloc_done <= n_alloc_done;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_alloc_done = r_alloc_done;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = w_in_op;
                    n_alloc_done = 1'b0;
                    unique case (w_in_op)
                        OP_CREATE, OP_TICK, OP_YIELD, OP_FORK: n_state = S_SCAN;
                        OP_KILL:                               n_state = S_KILL;
                        OP_EXIT, OP_SETPRIO:                   n_state = S_EXEC;
                        default:                               n_state = S_DONE;
                    endcase
                end
            end
            S_KILL: n_state = S_SCAN;
            S_SCAN: begin
                if (i_stat.cnt_last) begin
                    n_state = S_SCAN_DRAIN;
                end
            end
            S_SCAN_DRAIN: begin
                if (r_op == OP_CREATE || (r_op == OP_FORK && !r_alloc_done)) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_SCHED;
                end
            end
            S_ALLOC: begin
                n_alloc_done = 1'b1;
                n_state      = (r_op == OP_FORK) ? S_SCAN : S_DONE;
            end
            S_SCHED: n_state = (r_op == OP_YIELD) ? S_AGE : S_DONE;
            S_AGE: begin
                if (i_stat.cnt_last) begin
                    n_state = S_AGE_DRAIN;
                end
            end
            S_AGE_DRAIN: n_state = S_DONE;
            S_EXEC:      n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_in_valid;
                o_cmd.acc_clr = i_in_valid;
            end
            S_KILL: begin
                o_cmd.kill    = 1'b1;
                o_cmd.acc_clr = 1'b1;
            end
            S_SCAN: o_cmd.rd_en = 1'b1;
            S_ALLOC: begin
                o_cmd.alloc     = 1'b1;
                o_cmd.fork_prio = (r_op == OP_FORK);
                o_cmd.acc_clr   = 1'b1;
            end
            S_SCHED: o_cmd.sched = 1'b1;
            S_AGE: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.age   = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exit_wr = (r_op == OP_EXIT);
                o_cmd.prio_wr = (r_op == OP_SETPRIO);
            end
            S_DONE: o_cmd.load_out = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/pas_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pas_dpath
// Slot table datapath: valid bits, priority memory with a scan port,
// scan accumulators, running slot and the result register.
// ----------------------------------------------------------------------------
module pas_dpath
    import pas_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire logic [3:0]               i_target_slot,
    input  wire logic signed [PRIO_W-1:0] i_new_priority,
    input  wire logic                     i_out_stall,
    output t_stat                         o_stat,
    output logic                          o_out_valid,
    output logic [SLOT_OUT_W-1:0]         o_running_slot,
    output logic [SLOT_OUT_W-1:0]         o_allocated_slot,
    output logic                          o_status
);

    localparam int SW = $clog2(SLOTS);

    logic signed [PRIO_W-1:0] r_mem [SLOTS];

    logic [SLOTS-1:0]         r_valid, n_valid;
    logic [SW-1:0]            r_running, n_running;
    logic [SW-1:0]            r_cnt;
    logic                     r_rd_live, r_rd_age, r_rd_vbit;
    logic [SW-1:0]            r_rd_idx;
    logic signed [PRIO_W-1:0] r_rd_data;

    logic [3:0]               r_tgt;
    logic signed [PRIO_W-1:0] r_prio;

    logic                     r_free_found, r_best_found;
    logic [SW-1:0]            r_free_idx, r_pick;
    logic signed [PRIO_W-1:0] r_high, r_low, r_best;

    logic [SW-1:0]            r_alloc;
    logic                     r_status;

    logic                     r_out_valid;
    logic [SLOT_OUT_W-1:0]    r_out_running, r_out_alloc;
    logic                     r_out_status;

    logic                     w_cnt_last, w_acc, w_nonzero, w_tgt_ok;
    logic [SW-1:0]            w_tgt_idx;
    logic                     w_we;
    logic [SW-1:0]            w_waddr;
    logic signed [PRIO_W-1:0] w_wdata;

    assign w_cnt_last = (r_cnt == SW'(SLOTS - 1));
    assign w_acc      = r_rd_live && !r_rd_age;
    assign w_nonzero  = (r_rd_idx != '0);
    assign w_tgt_ok   = (int'(r_tgt) < SLOTS);
    assign w_tgt_idx  = SW'(r_tgt);

    assign o_stat.cnt_last = w_cnt_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // table write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_idx;
        w_wdata = sat_inc(r_rd_data);
        priority if (i_cmd.alloc) begin
            w_we    = r_free_found;
            w_waddr = r_free_idx;
            w_wdata = i_cmd.fork_prio ? sat_inc(r_high) : r_prio;
        end else if (i_cmd.sched) begin
            w_we    = (r_running != '0);
            w_waddr = r_running;
            w_wdata = demote(r_low);
        end else if (i_cmd.prio_wr) begin
            w_we    = w_tgt_ok;
            w_waddr = w_tgt_idx;
            w_wdata = r_prio;
        end else if (r_rd_live && r_rd_age) begin
            w_we    = r_rd_vbit && (r_rd_idx != r_running);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_cnt];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.alloc && r_free_found) begin
            n_valid[r_free_idx] = 1'b1;
        end
        if (i_cmd.kill) begin
            n_valid[r_running] = 1'b0;
        end
        if (i_cmd.exit_wr && w_tgt_ok) begin
            n_valid[w_tgt_idx] = 1'b0;
        end
    end

    always_comb begin
        n_running = r_running;
        if (i_cmd.sched) begin
            if (r_running == '0) begin
                n_running = r_best_found ? r_pick : '0;
            end else begin
                n_running = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_running   <= '0;
            r_cnt       <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_running <= n_running;
            r_rd_live <= i_cmd.rd_en;
            if (i_cmd.rd_en) begin
                r_cnt <= w_cnt_last ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan pipeline and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_idx  <= r_cnt;
            r_rd_age  <= i_cmd.age;
            r_rd_vbit <= r_valid[r_cnt];
        end
        if (i_cmd.capture) begin
            r_tgt    <= i_target_slot;
            r_prio   <= i_new_priority;
            r_alloc  <= '0;
            r_status <= 1'b0;
        end
        if (i_cmd.alloc) begin
            if (r_free_found) begin
                r_alloc <= r_free_idx;
            end else begin
                r_status <= 1'b1;
            end
        end
        if (i_cmd.acc_clr) begin
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_best_found <= 1'b0;
            r_pick       <= '0;
            r_best       <= PRIO_ZERO;
            r_high       <= PRIO_ZERO;
            r_low        <= DEMOTE_CEIL;
        end else if (w_acc) begin
            if (!r_free_found && !r_rd_vbit) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (r_rd_vbit && (!r_best_found || r_rd_data > r_best)) begin
                r_best_found <= 1'b1;
                r_best       <= r_rd_data;
                r_pick       <= r_rd_idx;
            end
            if (r_rd_vbit && w_nonzero && r_rd_data > r_high) begin
                r_high <= r_rd_data;
            end
            if (r_rd_vbit && w_nonzero && r_rd_data < r_low) begin
                r_low <= r_rd_data;
            end
        end
        if (i_cmd.load_out) begin
            r_out_running <= SLOT_OUT_W'(r_running);
            r_out_alloc   <= SLOT_OUT_W'(r_alloc);
            r_out_status  <= r_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_running_slot   = r_out_running;
    assign o_allocated_slot = r_out_alloc;
    assign o_status         = r_out_status;

endmodule
`default_nettype wire

/* sv/priority_aging_process_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_aging_process_scheduler
// Process slot table with priority scheduling, demotion and aging.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. The priority table is a
// memory with a single read port, so every scan visits one slot per cycle.
// A new request is taken while the previous result still waits in the
// output register.
module priority_aging_process_scheduler
    import pas_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_opcode,
    input  wire logic [3:0]               i_target_slot,
    input  wire logic signed [PRIO_W-1:0] i_new_priority,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [SLOT_OUT_W-1:0]         o_running_slot,
    output logic [SLOT_OUT_W-1:0]         o_allocated_slot,
    output logic                          o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign o_in_stall = !w_ready;

    pas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (w_stat),
        .o_ready    (w_ready),
        .o_cmd      (w_cmd)
    );

    pas_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_target_slot    (i_target_slot),
        .i_new_priority   (i_new_priority),
        .i_out_stall      (i_out_stall),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .o_running_slot   (o_running_slot),
        .o_allocated_slot (o_allocated_slot),
        .o_status         (o_status)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but sequencer stayed idle");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_allocated_slot == '0))
        else $error("full table result carries a slot");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled result");
`endif

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the priority aging process scheduler. A queue of requests
// (a directed opening, then weighted random commands) feeds a clocked
// driver. A local copy of the slot table predicts each outcome, and a
// clocked monitor compares every result against the oldest prediction.
// Both sides idle in random bursts, except in quiet stretches and the tail.
// ----------------------------------------------------------------------------
module tb;
    import pas_pkg::*;

    localparam int NUM_SLOTS   = SLOTS_DEF;
    localparam int RAND_ITEMS  = 520;
    localparam int QUIET_TAIL  = 100;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam int PRINT_LIMIT = 50;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [3:0]        slot;
        logic signed [15:0] prio;
    } t_request;

    typedef struct packed {
        logic [3:0] running;
        logic [3:0] alloc;
        logic       status;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              out_stall = 1'b0;
    logic [2:0]        req_op = '0;
    logic [3:0]        req_slot = '0;
    logic signed [15:0] req_prio = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [3:0]        o_running_slot;
    logic [3:0]        o_allocated_slot;
    logic              o_status;

    t_request request_queue[$];
    t_outcome due_outcomes[$];

    // predicted scheduler state
    logic              slot_used[NUM_SLOTS];
    logic signed [15:0] slot_prio[NUM_SLOTS];
    logic [3:0]        run_slot;

    int fail_count = 0;
    int sent_count = 0;
    int total_items = 0;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    priority_aging_process_scheduler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (req_op),
        .i_target_slot    (req_slot),
        .i_new_priority   (req_prio),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_running_slot   (o_running_slot),
        .o_allocated_slot (o_allocated_slot),
        .o_status         (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int bump(input int p);
        return (p >= int'(PRIO_MAX)) ? int'(PRIO_MAX) : p + 1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_used[i]) return i;
        end
        return -1;
    endfunction

    function automatic void reschedule();
        int  best;
        int  pick;
        int  low;
        int  demoted;
        bit  found;
        if (run_slot == 0) begin
            found = 0;
            best = 0;
            pick = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_used[i] && (!found || int'(slot_prio[i]) > best)) begin
                    found = 1;
                    best = int'(slot_prio[i]);
                    pick = i;
                end
            end
            run_slot = 4'(pick);
        end else begin
            low = int'(DEMOTE_CEIL);
            for (int i = 1; i < NUM_SLOTS; i++) begin
                if (slot_used[i] && int'(slot_prio[i]) < low) low = int'(slot_prio[i]);
            end
            if (low == int'(DEMOTE_CEIL)) begin
                demoted = 0;
            end else if (low <= int'(PRIO_MIN)) begin
                demoted = int'(PRIO_MIN);
            end else begin
                demoted = low - 1;
            end
            slot_prio[run_slot] = 16'(demoted);
            run_slot = '0;
        end
    endfunction

    function automatic t_outcome step_table(input t_request r);
        t_outcome res;
        int       free_idx;
        int       top;
        res = '0;
        case (r.op)
            OP_CREATE: begin
                free_idx = first_free();
                if (free_idx < 0) begin
                    res.status = 1'b1;
                end else begin
                    slot_used[free_idx] = 1'b1;
                    slot_prio[free_idx] = r.prio;
                    res.alloc = 4'(free_idx);
                end
            end
            OP_TICK: begin
                reschedule();
            end
            OP_YIELD: begin
                reschedule();
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (i != int'(run_slot) && slot_used[i])
                        slot_prio[i] = 16'(bump(int'(slot_prio[i])));
                end
            end
            OP_FORK: begin
                free_idx = first_free();
                if (free_idx < 0) begin
                    res.status = 1'b1;
                end else begin
                    top = 0;
                    for (int i = 1; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && int'(slot_prio[i]) > top) top = int'(slot_prio[i]);
                    end
                    slot_used[free_idx] = 1'b1;
                    slot_prio[free_idx] = 16'(bump(top));
                    res.alloc = 4'(free_idx);
                end
                reschedule();
            end
            OP_KILL: begin
                slot_used[run_slot] = 1'b0;
                reschedule();
            end
            OP_EXIT: begin
                slot_used[r.slot] = 1'b0;
            end
            OP_SETPRIO: begin
                slot_prio[r.slot] = r.prio;
            end
            default: begin
            end
        endcase
        res.running = run_slot;
        return res;
    endfunction

    function automatic bit idling_on();
        return (sent_count < total_items - QUIET_TAIL) && (((sent_count / 50) % 4) != 3);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
        end
        fail_count++;
    endtask

    task automatic add_request(input logic [2:0] op, input int slot, input int prio);
        t_request r;
        r.op = op;
        r.slot = 4'(slot);
        r.prio = 16'(prio);
        request_queue.push_back(r);
    endtask

    function automatic int pick_priority();
        case ($urandom_range(0, 7))
            0: return int'(PRIO_MAX);
            1: return int'(PRIO_MIN);
            2: return 990 + $urandom_range(0, 20);
            3: return 32760 + $urandom_range(0, 7);
            4: return -32768 + $urandom_range(0, 7);
            5: return $urandom_range(0, 6) - 3;
            default: return $signed($urandom_range(0, 65535) - 32768);
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_request item;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                item.op = req_op;
                item.slot = req_slot;
                item.prio = req_prio;
                due_outcomes.push_back(step_table(item));
                sent_count <= sent_count + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (idling_on() && $urandom_range(0, 4) == 0) begin
                    in_valid <= 1'b0;
                    gap_left <= $urandom_range(0, 18);
                end else if (request_queue.size() > 0) begin
                    item = request_queue.pop_front();
                    req_op <= item.op;
                    req_slot <= item.slot;
                    req_prio <= item.prio;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (due_outcomes.size() == 0) begin
                    report_mismatch("unrequested result, running slot", o_running_slot, -1);
                end else begin
                    want = due_outcomes.pop_front();
                    if (o_running_slot !== want.running)
                        report_mismatch("running slot", o_running_slot, want.running);
                    if (o_allocated_slot !== want.alloc)
                        report_mismatch("allocated slot", o_allocated_slot, want.alloc);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (idling_on() && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 18);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int r;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_prio[i] = '0;
        end
        run_slot = '0;

        // opening sequence: extremes, every command, corner cases
        add_request(OP_CREATE, 0, PRIO_MAX);
        add_request(OP_CREATE, 15, PRIO_MIN);
        add_request(OP_CREATE, 0, 0);
        add_request(OP_TICK, 0, 0);
        add_request(OP_YIELD, 0, 0);
        add_request(OP_TICK, 0, 0);
        add_request(OP_FORK, 0, 0);
        add_request(OP_KILL, 0, 0);
        add_request(OP_SETPRIO, 15, PRIO_MAX);
        add_request(OP_EXIT, 15, 0);
        add_request(OP_UNUSED, 15, -1);
        add_request(OP_TICK, 0, 0);
        add_request(OP_EXIT, 1, 0);
        add_request(OP_SETPRIO, 1, PRIO_MIN);
        for (int i = 0; i < 14; i++) add_request(OP_CREATE, i, int'(PRIO_MIN) + i);
        add_request(OP_CREATE, 0, 5);
        add_request(OP_FORK, 0, 0);
        add_request(OP_TICK, 0, 0);
        add_request(OP_KILL, 0, 0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 20)      add_request(OP_CREATE, $urandom_range(0, 15), pick_priority());
            else if (r < 38) add_request(OP_TICK, $urandom_range(0, 15), pick_priority());
            else if (r < 52) add_request(OP_YIELD, $urandom_range(0, 15), pick_priority());
            else if (r < 62) add_request(OP_FORK, $urandom_range(0, 15), pick_priority());
            else if (r < 72) add_request(OP_KILL, $urandom_range(0, 15), pick_priority());
            else if (r < 84) add_request(OP_EXIT, $urandom_range(0, 15), pick_priority());
            else if (r < 97) add_request(OP_SETPRIO, $urandom_range(0, 15), pick_priority());
            else             add_request(OP_UNUSED, $urandom_range(0, 15), pick_priority());
        end
        total_items = request_queue.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || in_valid || due_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (due_outcomes.size() > 0)
            report_mismatch("outstanding results", due_outcomes.size(), 0);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
